// ----- hdl/dtc_pkg.sv -----
// Shared constants and the per-cell control bundle for the decreasing triple counter.
`default_nettype none

package dtc_pkg;

    // Default sizing of the cell row and of one sequence value.
    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 30;

    // Width of the reported triple count; the total wraps at this width.
    localparam int COUNT_BITS = 28;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic load;   // shift a new value into the row
        logic copy;   // copy stored values into the token line, clear counters
        logic step;   // compare against the passing token, move tokens one cell
        logic drain;  // move counters and flags one cell toward the row's end
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/dtc_cell.sv -----
// One cell of the row: a stored value, a passing token and two pair counters.
`default_nettype none

module dtc_cell #(
    parameter int VALUE_BITS = dtc_pkg::VALUE_BITS_DEF,
    parameter int CNT_BITS   = 10
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  dtc_pkg::cell_ctrl_t         ctrl,
    input  wire [VALUE_BITS-1:0]        item_value,
    // Neighbor on the low side.
    input  wire [VALUE_BITS-1:0]        prev_value,
    input  wire                         prev_valid,
    input  wire                         prev_last,
    input  wire [VALUE_BITS-1:0]        prev_tval,
    input  wire                         prev_tvalid,
    input  wire                         prev_tlast,
    input  wire                         prev_twrap,
    input  wire [CNT_BITS-1:0]          prev_cnt_e,
    input  wire [CNT_BITS-1:0]          prev_cnt_a,
    // This cell's contents, handed to the neighbor on the high side.
    output logic [VALUE_BITS-1:0]       cur_value,
    output logic                        cur_valid,
    output logic                        cur_last,
    output logic [VALUE_BITS-1:0]       cur_tval,
    output logic                        cur_tvalid,
    output logic                        cur_tlast,
    output logic                        cur_twrap,
    output logic [CNT_BITS-1:0]         cur_cnt_e,
    output logic [CNT_BITS-1:0]         cur_cnt_a
);

    logic [VALUE_BITS-1:0] value_reg;
    logic                  valid_reg;
    logic                  last_reg;
    logic [VALUE_BITS-1:0] tval_reg;
    logic                  tvalid_reg;
    logic                  tlast_reg;
    logic                  twrap_reg;
    logic [CNT_BITS-1:0]   cnt_e_reg;
    logic [CNT_BITS-1:0]   cnt_a_reg;

    logic kill;
    logic smaller;

    // A newly loaded equal value means this copy is no longer the last occurrence.
    assign kill = ctrl.load & valid_reg & (value_reg == item_value);

    // The token counts only if it is a last occurrence with a smaller value.
    assign smaller = tvalid_reg & tlast_reg & (tval_reg < value_reg);

    assign cur_value  = value_reg;
    assign cur_valid  = valid_reg;
    assign cur_last   = last_reg & ~kill;
    assign cur_tval   = tval_reg;
    assign cur_tvalid = tvalid_reg;
    assign cur_tlast  = tlast_reg;
    assign cur_twrap  = twrap_reg;
    assign cur_cnt_e  = cnt_e_reg;
    assign cur_cnt_a  = cnt_a_reg;

    // Stored value line: shifts on load, flags also shift out during drain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (ctrl.load || ctrl.drain)
        begin
            valid_reg <= prev_valid;
            last_reg  <= prev_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= prev_value;
        end
    end

    // Token line: copied from the stored line, then rotated around the row.
    // A token that has passed the row's end came from an earlier position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
            tlast_reg  <= 1'b0;
            twrap_reg  <= 1'b0;
        end
        else if (ctrl.copy)
        begin
            tvalid_reg <= valid_reg;
            tlast_reg  <= last_reg;
            twrap_reg  <= 1'b0;
        end
        else if (ctrl.step)
        begin
            tvalid_reg <= prev_tvalid;
            tlast_reg  <= prev_tlast;
            twrap_reg  <= prev_twrap;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.copy)
        begin
            tval_reg <= value_reg;
        end
        else if (ctrl.step)
        begin
            tval_reg <= prev_tval;
        end
    end

    // Counters: earlier terms not smaller, and later smaller last occurrences.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_e_reg <= '0;
            cnt_a_reg <= '0;
        end
        else if (ctrl.copy)
        begin
            cnt_e_reg <= '0;
            cnt_a_reg <= '0;
        end
        else if (ctrl.step)
        begin
            if (twrap_reg && tvalid_reg && !smaller)
            begin
                cnt_e_reg <= cnt_e_reg + CNT_BITS'(1);
            end
            if (!twrap_reg && smaller)
            begin
                cnt_a_reg <= cnt_a_reg + CNT_BITS'(1);
            end
        end
        else if (ctrl.drain)
        begin
            cnt_e_reg <= prev_cnt_e;
            cnt_a_reg <= prev_cnt_a;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/decreasing_triple_counter.sv -----
// Top level: load sequencer, row of counting cells and the final multiply-accumulate.
//
//   channel   ports                                  transfer
//   --------  -------------------------------------  ------------------------------
//   input     start, busy, item_value, is_last       edge with start high, busy low
//   result    done, triple_count, overflowed         edge ending the cycle done high
//
// Loading takes one item per cycle; the row of cells shifts each value in.
// After the marked item the pass runs a copy state, token rotation steps around the row,
// drain steps into the single multiplier and a flush state; done is high in the
// cycle after the flush state.
// Reset clears the row's flags, counters and the sequencer; busy is low after it.
// The receiver cannot stall: done is high for exactly one cycle per result.
`default_nettype none

module decreasing_triple_counter #(
    parameter int MAX_ITEMS  = dtc_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = dtc_pkg::VALUE_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [VALUE_BITS-1:0]                item_value,
    input  wire                                 is_last,
    output logic                                done,
    output logic [dtc_pkg::COUNT_BITS-1:0]      triple_count,
    output logic                                overflowed
);

    localparam int CNT_BITS  = $clog2(MAX_ITEMS);
    localparam int NUM_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int PROD_BITS = 2 * CNT_BITS;
    localparam int CB        = dtc_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_STEP,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    state_t                 state_reg;
    logic [CNT_BITS-1:0]    cyc_reg;
    logic [NUM_BITS-1:0]    item_count_reg;
    logic                   overflow_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [CB-1:0]          acc_reg;
    logic                   done_reg;
    logic [CB-1:0]          triple_count_reg;
    logic                   overflowed_reg;

    dtc_pkg::cell_ctrl_t    ctrl;
    logic                   accept;
    logic                   room;
    logic                   cyc_end;
    logic [PROD_BITS-1:0]   mult;

    // Links between neighboring cells.
    logic [VALUE_BITS-1:0]  lk_value  [MAX_ITEMS];
    logic                   lk_valid  [MAX_ITEMS];
    logic                   lk_last   [MAX_ITEMS];
    logic [VALUE_BITS-1:0]  lk_tval   [MAX_ITEMS];
    logic                   lk_tvalid [MAX_ITEMS];
    logic                   lk_tlast  [MAX_ITEMS];
    logic                   lk_twrap  [MAX_ITEMS];
    logic [CNT_BITS-1:0]    lk_cnt_e  [MAX_ITEMS];
    logic [CNT_BITS-1:0]    lk_cnt_a  [MAX_ITEMS];

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start & ~busy;
    assign room         = (item_count_reg < NUM_BITS'(MAX_ITEMS));
    assign cyc_end      = (cyc_reg == CNT_BITS'(MAX_ITEMS - 1));
    assign done         = done_reg;
    assign triple_count = triple_count_reg;
    assign overflowed   = overflowed_reg;

    // Control broadcast to the row.
    always_comb
    begin
        ctrl.load  = accept & room;
        ctrl.copy  = (state_reg == ST_COPY);
        ctrl.step  = (state_reg == ST_STEP);
        ctrl.drain = (state_reg == ST_DRAIN);
    end

    // Row of cells; the first cell takes new items and the returning tokens.
    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            dtc_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_BITS   (CNT_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .item_value  (item_value),
                .prev_value  (item_value),
                .prev_valid  (ctrl.load),
                .prev_last   (1'b1),
                .prev_tval   (lk_tval[MAX_ITEMS-1]),
                .prev_tvalid (lk_tvalid[MAX_ITEMS-1]),
                .prev_tlast  (lk_tlast[MAX_ITEMS-1]),
                .prev_twrap  (1'b1),
                .prev_cnt_e  ('0),
                .prev_cnt_a  ('0),
                .cur_value   (lk_value[k]),
                .cur_valid   (lk_valid[k]),
                .cur_last    (lk_last[k]),
                .cur_tval    (lk_tval[k]),
                .cur_tvalid  (lk_tvalid[k]),
                .cur_tlast   (lk_tlast[k]),
                .cur_twrap   (lk_twrap[k]),
                .cur_cnt_e   (lk_cnt_e[k]),
                .cur_cnt_a   (lk_cnt_a[k])
            );
        end
        else
        begin : g_next
            dtc_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_BITS   (CNT_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .item_value  (item_value),
                .prev_value  (lk_value[k-1]),
                .prev_valid  (lk_valid[k-1]),
                .prev_last   (lk_last[k-1]),
                .prev_tval   (lk_tval[k-1]),
                .prev_tvalid (lk_tvalid[k-1]),
                .prev_tlast  (lk_tlast[k-1]),
                .prev_twrap  (lk_twrap[k-1]),
                .prev_cnt_e  (lk_cnt_e[k-1]),
                .prev_cnt_a  (lk_cnt_a[k-1]),
                .cur_value   (lk_value[k]),
                .cur_valid   (lk_valid[k]),
                .cur_last    (lk_last[k]),
                .cur_tval    (lk_tval[k]),
                .cur_tvalid  (lk_tvalid[k]),
                .cur_tlast   (lk_tlast[k]),
                .cur_twrap   (lk_twrap[k]),
                .cur_cnt_e   (lk_cnt_e[k]),
                .cur_cnt_a   (lk_cnt_a[k])
            );
        end
    end

    // Product of the two counters leaving the end of the row.
    assign mult = PROD_BITS'(lk_cnt_e[MAX_ITEMS-1]) * PROD_BITS'(lk_cnt_a[MAX_ITEMS-1]);

    // Sequencer, item count, accumulator and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cyc_reg          <= '0;
            item_count_reg   <= '0;
            overflow_reg     <= 1'b0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            done_reg         <= 1'b0;
            triple_count_reg <= '0;
            overflowed_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            item_count_reg <= item_count_reg + NUM_BITS'(1);
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (is_last)
                        begin
                            state_reg <= ST_COPY;
                        end
                    end
                end
                ST_COPY:
                begin
                    cyc_reg   <= '0;
                    prod_reg  <= '0;
                    acc_reg   <= '0;
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    if (cyc_end)
                    begin
                        cyc_reg   <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cyc_reg <= cyc_reg + CNT_BITS'(1);
                    end
                end
                ST_DRAIN:
                begin
                    // Only last occurrences of a value contribute a term.
                    if (lk_valid[MAX_ITEMS-1] && lk_last[MAX_ITEMS-1])
                    begin
                        prod_reg <= mult;
                    end
                    else
                    begin
                        prod_reg <= '0;
                    end
                    acc_reg <= acc_reg + CB'(prod_reg);
                    if (cyc_end)
                    begin
                        cyc_reg   <= '0;
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        cyc_reg <= cyc_reg + CNT_BITS'(1);
                    end
                end
                ST_FLUSH:
                begin
                    triple_count_reg <= acc_reg + CB'(prod_reg);
                    overflowed_reg   <= overflow_reg;
                    done_reg         <= 1'b1;
                    item_count_reg   <= '0;
                    overflow_reg     <= 1'b0;
                    state_reg        <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
